// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the core RTL.
// All checks are clocked on clk and held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tfb_pkg.sv
package tfb_pkg;

  // Store geometry
  localparam int FRAME_ROWS  = 64;
  localparam int ROW_BYTES   = 8;
  localparam int GLYPH_COUNT = 256;
  localparam int GLYPH_LINES = 8;
  localparam int BAND_ROWS   = 16;
  localparam int BIG_ROWS    = 2 * GLYPH_LINES;

  localparam int ROW_W       = $clog2(FRAME_ROWS);
  localparam int BYTE_W      = $clog2(ROW_BYTES);
  localparam int ROW_BITS    = ROW_BYTES * 8;
  localparam int LINE_W      = $clog2(GLYPH_LINES);
  localparam int GLYPH_BYTES = GLYPH_COUNT * GLYPH_LINES;
  localparam int GLYPH_AW    = $clog2(GLYPH_BYTES);
  // counts up to BIG_ROWS (big char at the last column touches one extra row)
  localparam int CNT_W       = $clog2(BIG_ROWS + 2);

  localparam logic [5:0] BAND_TOP_RESET = 6'd24;

  // Command codes
  typedef enum logic [2:0] {
    KIND_FONT_WR  = 3'd0,
    KIND_FB_WR    = 3'd1,
    KIND_FB_RD    = 3'd2,
    KIND_PUT_CHAR = 3'd3,
    KIND_BIG_CHAR = 3'd4,
    KIND_SCROLL   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_LAST,
    ST_RESP
  } state_t;

  // Command held for the duration of one item
  typedef struct packed {
    kind_t                kind;
    logic [BYTE_W-1:0]    col;
    logic [2:0]           row;
    logic [7:0]           code;
    logic [2:0]           step;
    logic [ROW_W-1:0]     fb_row;
    logic [BYTE_W-1:0]    fb_byte;
    logic [GLYPH_AW-1:0]  gaddr;
    logic [7:0]           wdata;
  } cmd_t;

  // Sequencer controls toward the memories and the result path
  typedef struct packed {
    logic                 fb_re;
    logic [ROW_W-1:0]     fb_raddr;
    logic                 glyph_re;
    logic [GLYPH_AW-1:0]  glyph_raddr;
    logic                 glyph_we;
    logic                 wb_valid;
    logic [ROW_W-1:0]     wb_row;
    logic [CNT_W-1:0]     wb_m;
    logic                 load_out;
  } ctl_t;

endpackage

// File: rtl/core/text_framebuffer_blitter_core.sv
// Text framebuffer blitter: 64x64 one-bit frame, 8 bytes per row, 256-glyph 8x8 font.
// Input channel (in_valid/in_ready) carries one command per transfer: font write,
// frame write, frame read, put char, put big char or scroll step. Every command
// returns exactly one result transfer on the output channel (out_valid/out_ready):
// the frame byte for a read, zero otherwise. band_top is written through its own
// channel (cfg_valid/cfg_ready, always ready); the user must write it only while no
// command is in flight; the block itself does not enforce this. Frame rows live in a
// row-wide memory; frame write, frame read, put char, big char and scroll read one row
// per cycle, and all but the frame read merge and write it back. Each command passes
// through issue steps, a last step and a response step that loads its result into the
// output register once it is free. Put char touches 8 rows, scroll 16 and big char 16
// (17 at the last column, spilling into the next row). One command is in flight.
// The output register holds a result while the receiver stalls; the command in
// flight then waits in its final step, and the next command is accepted the cycle
// after that result is loaded.
// Reset clears the frame at once through per-row valid bits (unwritten rows read
// as zero) and sets band_top to 24; font contents are undefined until written.
module text_framebuffer_blitter_core import tfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  band_top,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [2:0]  col,
  input  logic [2:0]  row,
  input  logic [7:0]  code,
  input  logic [2:0]  shift_step,
  input  logic [10:0] address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data
);

  `include "assert_macros.svh"

  cmd_t                cmd;
  ctl_t                ctl;
  logic [5:0]          band_first;
  logic                out_free;
  logic [FRAME_ROWS-1:0] row_valid;
  logic [ROW_BITS-1:0] fb_q;
  logic [ROW_BITS-1:0] old_row;
  logic [ROW_BITS-1:0] new_row;
  logic                fb_we;
  logic [7:0]          glyph_q;
  logic [7:0]          glyph_prev;
  logic [7:0]          sel_byte;
  logic [7:0]          rd_byte;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // band register
  always_ff @(posedge clk) begin
    if (rst) begin
      band_first <= BAND_TOP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      band_first <= band_top;
    end
  end

  tfb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .col        (col),
    .row        (row),
    .code       (code),
    .shift_step (shift_step),
    .address    (address),
    .write_data (write_data),
    .band_top   (band_first),
    .out_free   (out_free),
    .cmd        (cmd),
    .ctl        (ctl)
  );

  tfb_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (FRAME_ROWS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (fb_we),
    .waddr (ctl.wb_row),
    .wdata (new_row),
    .re    (ctl.fb_re),
    .raddr (ctl.fb_raddr),
    .rdata (fb_q)
  );

  tfb_ram #(
    .WIDTH (8),
    .DEPTH (GLYPH_BYTES)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (ctl.glyph_we),
    .waddr (cmd.gaddr),
    .wdata (cmd.wdata),
    .re    (ctl.glyph_re),
    .raddr (ctl.glyph_raddr),
    .rdata (glyph_q)
  );

  // rows never written since reset read as blank
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (fb_we) begin
      row_valid[ctl.wb_row] <= 1'b1;
    end
  end

  assign old_row = row_valid[ctl.wb_row] ? fb_q : '0;

  tfb_row_merge u_merge (
    .cmd        (cmd),
    .wb_valid   (ctl.wb_valid),
    .wb_m       (ctl.wb_m),
    .old_row    (old_row),
    .glyph_cur  (glyph_q),
    .glyph_prev (glyph_prev),
    .new_row    (new_row),
    .we         (fb_we),
    .sel_byte   (sel_byte)
  );

  // previous glyph line and read byte from the write-back stage
  always_ff @(posedge clk) begin
    if (ctl.wb_valid) begin
      glyph_prev <= glyph_q;
      rd_byte    <= sel_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl.load_out || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      read_data <= (cmd.kind == KIND_FB_RD) ? rd_byte : '0;
    end
  end

  `ASSERT_IMPLY(a_no_row_overlap, fb_we && ctl.fb_re, ctl.wb_row != ctl.fb_raddr, "row read and written in one cycle")
  `ASSERT_IMPLY(a_accept_quiet, in_valid && in_ready, !ctl.wb_valid && !out_free || !ctl.wb_valid, "command accepted during write-back")

endmodule

// File: rtl/core/tfb_ram.sv
module tfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/tfb_row_merge.sv
module tfb_row_merge import tfb_pkg::*; (
  input  cmd_t                cmd,
  input  logic                wb_valid,
  input  logic [CNT_W-1:0]    wb_m,
  input  logic [ROW_BITS-1:0] old_row,
  input  logic [7:0]          glyph_cur,
  input  logic [7:0]          glyph_prev,
  output logic [ROW_BITS-1:0] new_row,
  output logic                we,
  output logic [7:0]          sel_byte
);

  localparam logic [BYTE_W-1:0] LAST_BYTE = BYTE_W'(ROW_BYTES - 1);

  // byte 0 is the leftmost byte, held in the top bits of the row word
  function automatic logic [ROW_BITS-1:0] put_byte(input logic [ROW_BITS-1:0] w,
                                                   input logic [BYTE_W-1:0]   idx,
                                                   input logic [7:0]          b);
    logic [ROW_BITS-1:0] r;
    r = w;
    r[{~idx, 3'b000} +: 8] = b;
    return r;
  endfunction

  // each glyph bit becomes two pixels
  function automatic logic [15:0] double_bits(input logic [7:0] b);
    logic [15:0] d;
    for (int k = 0; k < 8; k++) begin
      d[2*k]   = b[k];
      d[2*k+1] = b[k];
    end
    return d;
  endfunction

  logic [15:0] cur_dbl;
  logic [15:0] prev_dbl;

  assign cur_dbl  = double_bits(glyph_cur);
  assign prev_dbl = double_bits(glyph_prev);
  assign sel_byte = old_row[{~cmd.fb_byte, 3'b000} +: 8];

  // new row contents per command
  always_comb begin
    new_row = old_row;
    case (cmd.kind)
      KIND_FB_WR: begin
        new_row = put_byte(old_row, cmd.fb_byte, cmd.wdata);
      end
      KIND_PUT_CHAR: begin
        new_row = put_byte(old_row, cmd.col, glyph_cur);
      end
      KIND_BIG_CHAR: begin
        if (wb_m < CNT_W'(BIG_ROWS)) begin
          new_row = put_byte(new_row, cmd.col, cur_dbl[15:8]);
          if (cmd.col != LAST_BYTE) begin
            new_row = put_byte(new_row, cmd.col + BYTE_W'(1), cur_dbl[7:0]);
          end
        end
        // low half spilled from the row above lands in byte 0
        if (cmd.col == LAST_BYTE && wb_m != '0) begin
          new_row = put_byte(new_row, '0, prev_dbl[7:0]);
        end
      end
      KIND_SCROLL: begin
        new_row = {old_row[ROW_BITS-2:0], glyph_cur[~cmd.step]};
      end
      default: begin
        new_row = old_row;
      end
    endcase
  end

  // write back only for commands that change the frame
  always_comb begin
    case (cmd.kind)
      KIND_FB_WR, KIND_PUT_CHAR, KIND_BIG_CHAR, KIND_SCROLL: we = wb_valid;
      default: we = 1'b0;
    endcase
  end

endmodule

// File: rtl/core/tfb_ctrl.sv
module tfb_ctrl import tfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [2:0]  col,
  input  logic [2:0]  row,
  input  logic [7:0]  code,
  input  logic [2:0]  shift_step,
  input  logic [10:0] address,
  input  logic [7:0]  write_data,
  input  logic [5:0]  band_top,
  input  logic        out_free,
  output cmd_t        cmd,
  output ctl_t        ctl
);

  `include "assert_macros.svh"

  localparam logic [BYTE_W-1:0] LAST_BYTE = BYTE_W'(ROW_BYTES - 1);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] last_cnt;
  logic             frame_op;
  logic             glyph_op;
  logic [ROW_W-1:0] issue_row;
  logic [LINE_W-1:0] issue_line;
  logic             wb_valid;
  logic [ROW_W-1:0] wb_row;
  logic [CNT_W-1:0] wb_m;

  // rows touched by each frame command, minus one (zero for the others)
  always_comb begin
    case (cmd.kind)
      KIND_PUT_CHAR: last_cnt = CNT_W'(GLYPH_LINES - 1);
      KIND_BIG_CHAR: last_cnt = (cmd.col == LAST_BYTE) ? CNT_W'(BIG_ROWS) : CNT_W'(BIG_ROWS - 1);
      KIND_SCROLL:   last_cnt = CNT_W'(BAND_ROWS - 1);
      default:       last_cnt = '0;
    endcase
  end

  // row and glyph line addressed at this step
  always_comb begin
    frame_op   = 1'b1;
    glyph_op   = 1'b1;
    issue_row  = cmd.fb_row;
    issue_line = cnt[LINE_W:1];
    case (cmd.kind)
      KIND_FB_WR, KIND_FB_RD: begin
        glyph_op = 1'b0;
      end
      KIND_PUT_CHAR: begin
        issue_row  = ROW_W'({cmd.row, 3'b000}) + ROW_W'(cnt);
        issue_line = cnt[LINE_W-1:0];
      end
      KIND_BIG_CHAR: begin
        issue_row = ROW_W'({cmd.row, 3'b000}) + ROW_W'(cnt);
      end
      KIND_SCROLL: begin
        issue_row = ROW_W'(band_top) + ROW_W'(cnt);
      end
      default: begin
        frame_op = 1'b0;
        glyph_op = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_ISSUE;
      ST_ISSUE: if (cnt == last_cnt) state_next = ST_LAST;
      ST_LAST:  state_next = ST_RESP;
      ST_RESP:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = (state == ST_IDLE);
    ctl.fb_re       = (state == ST_ISSUE) && frame_op;
    ctl.fb_raddr    = issue_row;
    ctl.glyph_re    = (state == ST_ISSUE) && glyph_op;
    ctl.glyph_raddr = {cmd.code, issue_line};
    ctl.glyph_we    = (state == ST_ISSUE) && (cmd.kind == KIND_FONT_WR);
    ctl.wb_valid    = wb_valid;
    ctl.wb_row      = wb_row;
    ctl.wb_m        = wb_m;
    ctl.load_out    = (state == ST_RESP) && out_free;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wb_valid <= 1'b0;
    end else begin
      state    <= state_next;
      wb_valid <= (state == ST_ISSUE) && frame_op;
    end
  end

  // step counter, write-back stage and command capture
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      cnt <= '0;
    end else if (state == ST_ISSUE) begin
      cnt <= cnt + CNT_W'(1);
    end
    wb_row <= issue_row;
    wb_m   <= cnt;
    if (in_valid && in_ready) begin
      cmd.kind    <= kind_t'(kind);
      cmd.col     <= col;
      cmd.row     <= row;
      cmd.code    <= code;
      cmd.step    <= shift_step;
      cmd.fb_row  <= address[ROW_W+BYTE_W-1:BYTE_W];
      cmd.fb_byte <= address[BYTE_W-1:0];
      cmd.gaddr   <= address[GLYPH_AW-1:0];
      cmd.wdata   <= write_data;
    end
  end

  `ASSERT_NEXT(a_issue_then_wb, ctl.fb_re, wb_valid, "frame read not followed by write-back")
  `ASSERT_IMPLY(a_cnt_range, state == ST_ISSUE, cnt <= CNT_W'(BIG_ROWS), "step count out of range")

endmodule
